// ----- design/byte_ring_fifo_with_line_read_assert.svh -----
// Assertion macros shared by the byte ring FIFO RTL.
// Depends on nothing; take in with `include inside a module body.
`ifndef BYTE_RING_FIFO_WITH_LINE_READ_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_LINE_READ_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/brf_pkg.sv -----
// Shared constants for the byte ring FIFO with line read.
// No dependencies; used by brf_ring_add and the top level.
package brf_pkg;

	localparam int DEPTH      = 1024;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CAP_W      = PTR_W + 1;
	localparam int MAX_LINE   = 64;
	localparam int LEN_W      = $clog2(MAX_LINE) + 1;
	localparam int LINE_W     = $clog2(MAX_LINE);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = CAP_W;
	localparam int DROP_W     = 32;

	localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);
	localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(DEPTH);
	localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
	localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_LINE);
	localparam logic [7:0]       NEWLINE   = 8'h0A;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LINE = 1'b1;

	// Action codes
	localparam logic [2:0] ACT_PUSH      = 3'd0;
	localparam logic [2:0] ACT_POP       = 3'd1;
	localparam logic [2:0] ACT_PEEK      = 3'd2;
	localparam logic [2:0] ACT_DISCARD   = 3'd3;
	localparam logic [2:0] ACT_CLEAR     = 3'd4;
	localparam logic [2:0] ACT_READ_LINE = 3'd5;

	// Status codes
	localparam logic [2:0] STS_OK      = 3'd0;
	localparam logic [2:0] STS_FULL    = 3'd1;
	localparam logic [2:0] STS_EMPTY   = 3'd2;
	localparam logic [2:0] STS_NO_LINE = 3'd3;
	localparam logic [2:0] STS_TOO_LONG = 3'd4;

endpackage

// ----- design/brf_ring_add.sv -----
// Shared ring-pointer adder: base plus offset, wrapped at the capacity in use.
// Depends on brf_pkg; the sum wraps correctly only while both operands stay below the capacity.
module brf_ring_add (
	input  logic [brf_pkg::PTR_W-1:0] base,
	input  logic [brf_pkg::PTR_W-1:0] offs,
	input  logic [brf_pkg::CAP_W-1:0] cap,
	output logic [brf_pkg::PTR_W-1:0] sum
);

	logic [brf_pkg::CAP_W-1:0] raw;
	logic [brf_pkg::CAP_W-1:0] wrapped;

	// Add, then subtract the capacity once if the sum reaches or passes it
	always_comb begin
		raw     = {1'b0, base} + {1'b0, offs};
		wrapped = (raw >= cap) ? (raw - cap) : raw;
		sum     = wrapped[brf_pkg::PTR_W-1:0];
	end

endmodule

// ----- design/byte_ring_fifo_with_line_read.sv -----
// Byte ring FIFO with line read: top level, sequencer and byte store.
// Depends on brf_pkg, brf_ring_add and byte_ring_fifo_with_line_read_assert.svh.
//
// One action per start beat; busy stays high until the final result beat is on the ports, and
// each result beat sits on the ports for one cycle marked by done, with last on the final one;
// the receiver cannot stall. Push, discard, clear and unknown actions pass through the execute
// state alone. Pop and peek add a show state when they return a byte (one registered read of the
// byte store) and skip it when the ring is empty or the offset is beyond the fill. Read line runs
// the execute state, a scan of n held bytes up to and including the newline (or the whole fill
// when there is none), then the delivery of L bytes (0 for a line that is too long or missing);
// the scan and the delivery each read one byte per cycle through the same store port and the one
// shared ring adder. Configuration writes are taken while idle.
module byte_ring_fifo_with_line_read (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     action,
	input  logic [7:0]                     byte_in,
	input  logic [brf_pkg::PTR_W-1:0]      count,
	output logic                           done,
	output logic [2:0]                     status,
	output logic [7:0]                     byte_out,
	output logic [brf_pkg::PTR_W-1:0]      fill_level,
	output logic [brf_pkg::DROP_W-1:0]     drop_total,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [brf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brf_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_EXEC = 5'b00010,
		ST_SHOW = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_LINE = 5'b10000
	} state_t;

	state_t                         state_q;
	logic [2:0]                     action_q;
	logic [7:0]                     byte_in_q;
	logic [brf_pkg::PTR_W-1:0]      count_q;
	logic [brf_pkg::PTR_W-1:0]      rp_q;
	logic [brf_pkg::PTR_W-1:0]      wp_q;
	logic [brf_pkg::CAP_W-1:0]      cap_q;
	logic [brf_pkg::LEN_W-1:0]      max_len_q;
	logic [brf_pkg::DROP_W-1:0]     drop_q;
	logic [brf_pkg::PTR_W-1:0]      walk_q;
	logic [brf_pkg::PTR_W-1:0]      scan_idx_q;
	logic [brf_pkg::LINE_W-1:0]     line_left_q;
	logic [7:0]                     rd_data_q;
	logic [7:0]                     store_q [brf_pkg::DEPTH];
	logic                           done_q;
	logic [2:0]                     status_q;
	logic [7:0]                     byte_out_q;
	logic                           last_q;

	logic [brf_pkg::CAP_W-1:0]      fill_w;
	logic [brf_pkg::PTR_W-1:0]      fill;
	logic [brf_pkg::PTR_W-1:0]      disc_cnt;
	logic [brf_pkg::PTR_W-1:0]      add_base;
	logic [brf_pkg::PTR_W-1:0]      add_offs;
	logic [brf_pkg::PTR_W-1:0]      nxt;
	logic                           push_full;
	logic                           is_nl;
	logic [brf_pkg::CAP_W-1:0]      run_len;
	logic                           rd_en;
	logic [brf_pkg::PTR_W-1:0]      rd_addr;
	logic                           wr_en;
	logic                           cfg_fire;
	logic                           ptrs_ok;
	logic                           full_beat;

	function automatic logic [brf_pkg::CAP_W-1:0] clamp_cap(input logic [brf_pkg::CAP_W-1:0] v);
		if (v < brf_pkg::CAP_MIN) return brf_pkg::CAP_MIN;
		if (v > brf_pkg::CAP_MAX) return brf_pkg::CAP_MAX;
		return v;
	endfunction

	function automatic logic [brf_pkg::LEN_W-1:0] clamp_len(input logic [brf_pkg::LEN_W-1:0] v);
		if (v < brf_pkg::LEN_MIN) return brf_pkg::LEN_MIN;
		if (v > brf_pkg::LEN_MAX) return brf_pkg::LEN_MAX;
		return v;
	endfunction

	// Fill level from the pointers
	always_comb begin
		if (wp_q >= rp_q) begin
			fill_w = {1'b0, wp_q} - {1'b0, rp_q};
		end else begin
			fill_w = cap_q - {1'b0, rp_q} + {1'b0, wp_q};
		end
		fill     = fill_w[brf_pkg::PTR_W-1:0];
		disc_cnt = (count_q > fill) ? fill : count_q;
	end

	// Pick the operands of the shared ring adder
	always_comb begin
		add_base = rp_q;
		add_offs = brf_pkg::PTR_W'(1);
		unique case (state_q)
			ST_EXEC: begin
				if (action_q == brf_pkg::ACT_PUSH) begin
					add_base = wp_q;
				end else if (action_q == brf_pkg::ACT_PEEK) begin
					add_offs = count_q;
				end else if (action_q == brf_pkg::ACT_DISCARD) begin
					add_offs = disc_cnt;
				end
			end
			ST_SCAN, ST_LINE: begin
				add_base = walk_q;
			end
			default: begin
			end
		endcase
	end

	brf_ring_add u_ring_add (
		.base (add_base),
		.offs (add_offs),
		.cap  (cap_q),
		.sum  (nxt)
	);

	assign push_full = (nxt == rp_q);
	assign is_nl     = (rd_data_q == brf_pkg::NEWLINE);
	assign run_len   = {1'b0, scan_idx_q} + brf_pkg::CAP_W'(1);
	assign cfg_fire  = cfg_valid && cfg_ready;

	// Store port control: one read and one write per cycle
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rp_q;
		wr_en   = 1'b0;
		unique case (state_q)
			ST_EXEC: begin
				if (action_q == brf_pkg::ACT_PUSH) begin
					wr_en = !push_full;
				end else if (action_q == brf_pkg::ACT_POP) begin
					rd_en = (fill != '0);
				end else if (action_q == brf_pkg::ACT_PEEK) begin
					rd_en   = (count_q < fill);
					rd_addr = nxt;
				end else if (action_q == brf_pkg::ACT_READ_LINE) begin
					rd_en = (fill != '0);
				end
			end
			ST_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = is_nl ? rp_q : nxt;
			end
			ST_LINE: begin
				rd_en   = (line_left_q != brf_pkg::LINE_W'(1));
				rd_addr = nxt;
			end
			default: begin
			end
		endcase
	end

	// Byte store: write at the tail, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wp_q] <= byte_in_q;
		end
		if (rd_en) begin
			rd_data_q <= store_q[rd_addr];
		end
	end

	// Sequencer, pointers, registers and result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rp_q      <= '0;
			wp_q      <= '0;
			cap_q     <= brf_pkg::CAP_MAX;
			max_len_q <= brf_pkg::LEN_MAX;
			drop_q    <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_fire) begin
				if (cfg_index == brf_pkg::REG_CAPACITY) begin
					cap_q <= clamp_cap(cfg_data);
					rp_q  <= '0;
					wp_q  <= '0;
				end else if (cfg_index == brf_pkg::REG_MAX_LINE) begin
					max_len_q <= clamp_len(cfg_data[brf_pkg::LEN_W-1:0]);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						action_q  <= action;
						byte_in_q <= byte_in;
						count_q   <= count;
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					status_q   <= brf_pkg::STS_OK;
					byte_out_q <= 8'h00;
					last_q     <= 1'b1;
					done_q     <= 1'b1;
					state_q    <= ST_IDLE;
					unique case (action_q)
						brf_pkg::ACT_PUSH: begin
							if (push_full) begin
								drop_q   <= drop_q + brf_pkg::DROP_W'(1);
								status_q <= brf_pkg::STS_FULL;
							end else begin
								wp_q <= nxt;
							end
						end
						brf_pkg::ACT_POP: begin
							if (fill == '0) begin
								status_q <= brf_pkg::STS_EMPTY;
							end else begin
								rp_q    <= nxt;
								done_q  <= 1'b0;
								state_q <= ST_SHOW;
							end
						end
						brf_pkg::ACT_PEEK: begin
							if (count_q >= fill) begin
								status_q <= brf_pkg::STS_EMPTY;
							end else begin
								done_q  <= 1'b0;
								state_q <= ST_SHOW;
							end
						end
						brf_pkg::ACT_DISCARD: begin
							rp_q <= nxt;
						end
						brf_pkg::ACT_CLEAR: begin
							rp_q <= wp_q;
						end
						brf_pkg::ACT_READ_LINE: begin
							if (fill == '0) begin
								status_q <= brf_pkg::STS_NO_LINE;
							end else begin
								walk_q     <= rp_q;
								scan_idx_q <= '0;
								done_q     <= 1'b0;
								state_q    <= ST_SCAN;
							end
						end
						default: begin
						end
					endcase
				end
				ST_SHOW: begin
					status_q   <= brf_pkg::STS_OK;
					byte_out_q <= rd_data_q;
					last_q     <= 1'b1;
					done_q     <= 1'b1;
					state_q    <= ST_IDLE;
				end
				ST_SCAN: begin
					if (is_nl) begin
						rp_q <= nxt;
						if (run_len >= brf_pkg::CAP_W'(max_len_q)) begin
							status_q   <= brf_pkg::STS_TOO_LONG;
							byte_out_q <= 8'h00;
							last_q     <= 1'b1;
							done_q     <= 1'b1;
							state_q    <= ST_IDLE;
						end else begin
							walk_q      <= rp_q;
							line_left_q <= run_len[brf_pkg::LINE_W-1:0];
							state_q     <= ST_LINE;
						end
					end else if (run_len == brf_pkg::CAP_W'(fill)) begin
						status_q   <= brf_pkg::STS_NO_LINE;
						byte_out_q <= 8'h00;
						last_q     <= 1'b1;
						done_q     <= 1'b1;
						state_q    <= ST_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + brf_pkg::PTR_W'(1);
						walk_q     <= nxt;
					end
				end
				ST_LINE: begin
					status_q   <= brf_pkg::STS_OK;
					byte_out_q <= rd_data_q;
					last_q     <= (line_left_q == brf_pkg::LINE_W'(1));
					done_q     <= 1'b1;
					if (line_left_q == brf_pkg::LINE_W'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						line_left_q <= line_left_q - brf_pkg::LINE_W'(1);
						walk_q      <= nxt;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Drive the ports
	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = (state_q == ST_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign byte_out   = byte_out_q;
	assign fill_level = fill;
	assign drop_total = drop_q;
	assign last       = last_q;

	// Terms for the checks below
	assign ptrs_ok   = ({1'b0, rp_q} < cap_q) && ({1'b0, wp_q} < cap_q);
	assign full_beat = done && (status == brf_pkg::STS_FULL);

	`include "byte_ring_fifo_with_line_read_assert.svh"

	`BRF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, start && !busy, busy, "busy not raised")
	`BRF_ASSERT_NOW(a_ptrs_in_ring, clk, arst_n, 1'b1, ptrs_ok, "pointer beyond capacity")
	`BRF_ASSERT_NOW(a_one_slot_free, clk, arst_n, 1'b1, fill_w < cap_q, "fill reached capacity")
	`BRF_ASSERT_NEXT(a_line_unbroken, clk, arst_n, done && !last, done, "gap inside a line")
	`BRF_ASSERT_NOW(a_drop_on_full, clk, arst_n, !$stable(drop_q), full_beat, "unexpected drop")

endmodule

// ----- tb/brf_checker.sv -----
// Scoreboard for the byte ring FIFO with line read: mirrors ring state and register values.
// Watches the action, result and register-write channels of the block; needs brf_pkg.
// Reports mismatches itself and hands its counts back to the testbench top.
module brf_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [2:0]                     action,
	input  logic [7:0]                     byte_in,
	input  logic [brf_pkg::PTR_W-1:0]      count,
	input  logic                           done,
	input  logic [2:0]                     status,
	input  logic [7:0]                     byte_out,
	input  logic [brf_pkg::PTR_W-1:0]      fill_level,
	input  logic [brf_pkg::DROP_W-1:0]     drop_total,
	input  logic                           last,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [brf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brf_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             fail_count,
	output int                             outstanding,
	output int                             beats_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import brf_pkg::*;

	typedef struct packed {
		logic [2:0]        status;
		logic [7:0]        byte_out;
		logic [PTR_W-1:0]  fill;
		logic [DROP_W-1:0] drops;
		logic              last;
	} fifo_reply_t;

	// Mirror of the ring and its registers
	logic [7:0]        ring_mem [DEPTH];
	int                rd_ptr;
	int                wr_ptr;
	int                ring_size;
	int                line_cap;
	logic [DROP_W-1:0] drops;

	fifo_reply_t due_replies [$];
	int          errors;
	int          compared;

	function automatic int ring_step(input int base, input int step);
		return (base + step) % ring_size;
	endfunction

	function automatic int held_bytes();
		return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : ring_size - rd_ptr + wr_ptr;
	endfunction

	// Queue one expected beat; fill is taken after the whole action
	function automatic void queue_reply(input logic [2:0] st, input logic [7:0] b,
	                                    input logic fin);
		fifo_reply_t r;
		r.status   = st;
		r.byte_out = b;
		r.fill     = PTR_W'(held_bytes());
		r.drops    = drops;
		r.last     = fin;
		due_replies.push_back(r);
	endfunction

	// Work out the beats that one accepted action gives and advance the mirror
	task automatic model_fifo_action(input logic [2:0] act, input logic [7:0] din,
	                                 input logic [PTR_W-1:0] offs);
		int         held;
		int         nxt;
		int         scan;
		int         span;
		int         head;
		int         k;
		logic [2:0] st;
		logic [7:0] rb;
		held = held_bytes();
		st   = STS_OK;
		rb   = 8'h00;
		case (act)
			ACT_PUSH: begin
				nxt = ring_step(wr_ptr, 1);
				if (nxt == rd_ptr) begin
					drops = drops + 1'b1;
					st    = STS_FULL;
				end else begin
					ring_mem[wr_ptr] = din;
					wr_ptr           = nxt;
				end
			end
			ACT_POP: begin
				if (held == 0) begin
					st = STS_EMPTY;
				end else begin
					rb     = ring_mem[rd_ptr];
					rd_ptr = ring_step(rd_ptr, 1);
				end
			end
			ACT_PEEK: begin
				if (int'(offs) >= held) st = STS_EMPTY;
				else rb = ring_mem[ring_step(rd_ptr, int'(offs))];
			end
			ACT_DISCARD: begin
				rd_ptr = ring_step(rd_ptr, (int'(offs) > held) ? held : int'(offs));
			end
			ACT_CLEAR: begin
				rd_ptr = wr_ptr;
			end
			ACT_READ_LINE: begin
				scan = 0;
				while (scan < held && ring_mem[ring_step(rd_ptr, scan)] != NEWLINE)
					scan++;
				if (scan == held) begin
					st = STS_NO_LINE;
				end else begin
					span   = scan + 1;
					head   = rd_ptr;
					rd_ptr = ring_step(rd_ptr, span);
					if (span > line_cap - 1) begin
						st = STS_TOO_LONG;
					end else begin
						// One beat per line byte, newline included
						for (k = 0; k < span; k++)
							queue_reply(STS_OK, ring_mem[ring_step(head, k)], k == span - 1);
						return;
					end
				end
			end
			default: ;
		endcase
		queue_reply(st, rb, 1'b1);
	endtask

	task automatic check_field(input string name, input logic [DROP_W-1:0] want,
	                           input logic [DROP_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		fifo_reply_t want;
		logic [CAP_W-1:0] cap_req;
		logic [LEN_W-1:0] len_req;
		if (!arst_n) begin
			rd_ptr    = 0;
			wr_ptr    = 0;
			ring_size = DEPTH;
			line_cap  = MAX_LINE;
			drops     = '0;
			errors    = 0;
			compared  = 0;
			due_replies.delete();
		end else begin
			// Compare the result beat with the oldest expectation
			if (done) begin
				if (due_replies.size() == 0) begin
					$error("result beat with no action awaiting one (status %0d, byte %0d)",
					       status, byte_out);
					errors++;
				end else begin
					want = due_replies.pop_front();
					check_field("status", DROP_W'(want.status), DROP_W'(status));
					check_field("byte_out", DROP_W'(want.byte_out), DROP_W'(byte_out));
					check_field("fill_level", DROP_W'(want.fill), DROP_W'(fill_level));
					check_field("drop_total", want.drops, drop_total);
					check_field("last", DROP_W'(want.last), DROP_W'(last));
					compared++;
				end
			end
			// Register writes: a capacity change empties the ring
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CAPACITY) begin
					cap_req   = cfg_data[CAP_W-1:0];
					ring_size = (cap_req < CAP_MIN) ? int'(CAP_MIN) :
					            (cap_req > CAP_MAX) ? int'(CAP_MAX) : int'(cap_req);
					rd_ptr    = 0;
					wr_ptr    = 0;
				end else if (cfg_index == REG_MAX_LINE) begin
					len_req  = cfg_data[LEN_W-1:0];
					line_cap = (len_req < LEN_MIN) ? int'(LEN_MIN) :
					           (len_req > LEN_MAX) ? int'(LEN_MAX) : int'(len_req);
				end
			end
			if (start && !busy)
				model_fifo_action(action, byte_in, count);
		end
		fail_count    <= errors;
		outstanding   <= due_replies.size();
		beats_checked <= compared;
	end

endmodule

// ----- tb/tb.sv -----
// Testbench top for byte_ring_fifo_with_line_read: clock, reset, actions and register writes.
// Depends on brf_pkg, the block itself and brf_checker, which does all result checking.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import brf_pkg::*;

	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	localparam int         PHASES      = 8;
	localparam int         PHASE_ITEMS = 56;
	localparam int         QUIET_LIMIT = 4000;

	logic                  clk;
	logic                  arst_n     = 1'b0;
	logic                  start      = 1'b0;
	logic                  busy;
	logic [2:0]            action     = ACT_PUSH;
	logic [7:0]            byte_in    = 8'h00;
	logic [PTR_W-1:0]      count      = '0;
	logic                  done;
	logic [2:0]            status;
	logic [7:0]            byte_out;
	logic [PTR_W-1:0]      fill_level;
	logic [DROP_W-1:0]     drop_total;
	logic                  last;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = REG_CAPACITY;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;
	int                    fail_count;
	int                    outstanding;
	int                    beats_checked;

	// Register settings per phase, extremes and out-of-range values among them
	logic [CFG_DATA_W-1:0] cap_plan  [PHASES] = '{11'd2047, 11'd3, 11'd17, 11'd1,
	                                              11'd1024, 11'd200, 11'd1023, 11'd5};
	logic [CFG_DATA_W-1:0] len_plan  [PHASES] = '{11'h7FF, 11'd3, 11'd8, 11'h50A,
	                                              11'd64, 11'd1, 11'd63, 11'd6};
	int                    idle_plan [PHASES] = '{25, 45, 0, 20, 45, 10, 0, 0};

	int actions_sent;
	int settings_used;
	int idle_pct;
	int line_room;

	byte_ring_fifo_with_line_read i_dut (.*);

	brf_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up when nothing has moved on any channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet = 0;
			else quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	// Present one action, after an optional idle burst, and hold it until accepted
	task automatic send_action(input logic [2:0] act, input logic [7:0] b,
	                           input logic [PTR_W-1:0] cnt);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		start   <= 1'b1;
		action  <= act;
		byte_in <= b;
		count   <= cnt;
		do @(posedge clk); while (busy);
		actions_sent++;
	endtask

	// Drop start and wait until every expected beat is back and the block is idle
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Push a line body free of newlines, then its newline
	task automatic push_line(input int body);
		logic [7:0] ch;
		int         n;
		for (n = 0; n < body; n++) begin
			ch = 8'($urandom);
			if (ch == NEWLINE) ch = ~NEWLINE;
			send_action(ACT_PUSH, ch, PTR_W'($urandom));
		end
		send_action(ACT_PUSH, NEWLINE, PTR_W'($urandom));
	endtask

	// Mostly well-formed lines and reads, with pops, peeks, discards and noise between
	task automatic random_traffic(input int target);
		int pick;
		int body;
		while (actions_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				body = ($urandom_range(3) == 0) ? $urandom_range(0, line_room + 2) :
				                                  $urandom_range(0, line_room - 2);
				push_line(body);
				if ($urandom_range(1) == 1)
					send_action(ACT_READ_LINE, 8'($urandom), PTR_W'($urandom));
			end else if (pick < 50) begin
				send_action(ACT_READ_LINE, 8'($urandom), PTR_W'($urandom));
			end else if (pick < 62) begin
				send_action(ACT_PUSH, 8'($urandom), PTR_W'($urandom));
			end else if (pick < 72) begin
				send_action(ACT_POP, 8'($urandom), PTR_W'($urandom));
			end else if (pick < 80) begin
				send_action(ACT_PEEK, 8'($urandom), ($urandom_range(1) == 1) ?
				            PTR_W'($urandom_range(0, 20)) : PTR_W'($urandom));
			end else if (pick < 87) begin
				send_action(ACT_DISCARD, 8'($urandom), ($urandom_range(3) == 0) ?
				            PTR_W'($urandom) : PTR_W'($urandom_range(0, 4)));
			end else if (pick < 90) begin
				send_action(ACT_CLEAR, 8'($urandom), PTR_W'($urandom));
			end else if (pick < 93) begin
				send_action(($urandom_range(1) == 1) ? ACT_SPARE_6 : ACT_SPARE_7,
				            8'($urandom), PTR_W'($urandom));
			end else begin
				send_action(3'($urandom), 8'($urandom), PTR_W'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		int ph;
		actions_sent  = 0;
		settings_used = 1;
		idle_pct      = 0;
		line_room     = MAX_LINE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty ring, offset and count extremes, line found and missing, spare codes
		send_action(ACT_POP, 8'hFF, '1);
		send_action(ACT_PEEK, 8'h00, '0);
		send_action(ACT_READ_LINE, 8'h00, '0);
		send_action(ACT_DISCARD, 8'hFF, '1);
		send_action(ACT_PUSH, 8'h00, '0);
		send_action(ACT_PUSH, 8'hFF, '1);
		send_action(ACT_PEEK, 8'h00, PTR_W'(1));
		send_action(ACT_PEEK, 8'h00, '1);
		send_action(ACT_READ_LINE, 8'hFF, '1);
		send_action(ACT_PUSH, NEWLINE, '0);
		send_action(ACT_READ_LINE, 8'h00, '0);
		send_action(ACT_PUSH, 8'h55, '0);
		send_action(ACT_PUSH, 8'hAA, '0);
		send_action(ACT_DISCARD, 8'h00, '1);
		send_action(ACT_PUSH, 8'h33, '0);
		send_action(ACT_CLEAR, 8'h00, '0);
		send_action(ACT_POP, 8'h00, '0);
		send_action(ACT_SPARE_6, 8'hA5, PTR_W'(10'h2AA));
		send_action(ACT_SPARE_7, 8'h5A, PTR_W'(10'h155));

		// Smallest ring and line buffer: one usable byte, drop on full, one-byte line
		write_reg(REG_CAPACITY, '0);
		write_reg(REG_MAX_LINE, '0);
		settings_used++;
		send_action(ACT_PUSH, 8'h41, '0);
		send_action(ACT_PUSH, 8'h42, '0);
		send_action(ACT_POP, 8'h00, '0);
		send_action(ACT_PUSH, NEWLINE, '0);
		send_action(ACT_READ_LINE, 8'h00, '0);

		// Random phases, one register setting each; the final ones run without idling
		for (ph = 0; ph < PHASES; ph++) begin
			write_reg(REG_CAPACITY, cap_plan[ph]);
			write_reg(REG_MAX_LINE, len_plan[ph]);
			settings_used++;
			line_room = int'(len_plan[ph][LEN_W-1:0]);
			if (line_room < 2) line_room = 2;
			else if (line_room > MAX_LINE) line_room = MAX_LINE;
			idle_pct = idle_plan[ph];
			random_traffic(actions_sent + PHASE_ITEMS);
		end

		drain();
		repeat (70) @(posedge clk);
		$display("Drove %0d actions under %0d register settings; %0d result beats compared.",
		         actions_sent, settings_used, beats_checked);
		$display("Covered pushes to full, pops, peeks, clamped discards, clears and line reads.");
		if (fail_count == 0 && outstanding == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
